FILE: hdl/average_pooling_window_defines.svh
// assertion macros shared by the average pooling window rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef AVERAGE_POOLING_WINDOW_DEFINES_SVH
`define AVERAGE_POOLING_WINDOW_DEFINES_SVH

`ifndef SYNTHESIS
`define APW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("apw assertion failed");
`define APW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("apw assertion failed");
`else
`define APW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define APW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/apw_pkg.sv
// shared constants, types and helpers of the average pooling window
// no dependencies
package apw_pkg;

    localparam int PIXEL_BITS  = 16;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_POOL    = 5;
    localparam int MAX_WIDTH   = 4096;

    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int SLOT_BITS   = $clog2(MAX_POOL);

    localparam int POOL_BITS   = 3;
    localparam int STRIDE_BITS = 4;
    localparam int WREG_BITS   = 13;
    localparam int HREG_BITS   = 9;

    localparam int CFG_DATA_BITS = 13;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STRIDE    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IN_HEIGHT = 2'd3;

    localparam int DIV_BITS  = $clog2(MAX_POOL * MAX_POOL + 1);
    localparam int SUM_BITS  = PIXEL_BITS + $clog2(MAX_POOL * MAX_POOL);
    localparam int CNT_BITS  = $clog2(SUM_BITS);

    localparam int STORE_DEPTH     = MAX_POOL * MAX_HEIGHT;
    localparam int STORE_ADDR_BITS = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic                start;
        logic [SUM_BITS-1:0] dividend;
        logic [DIV_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [SUM_BITS-1:0] quotient;
        logic [DIV_BITS-1:0] remainder;
    } t_div_rsp;

    function automatic logic [DIV_BITS-1:0] pool_divisor(input logic [POOL_BITS-1:0] k);
        logic [DIV_BITS-1:0] kw;
        kw = DIV_BITS'(k);
        return kw * kw;
    endfunction

    function automatic logic [STORE_ADDR_BITS-1:0] store_addr(
        input logic [SLOT_BITS-1:0] slot,
        input logic [ROW_BITS-1:0]  row
    );
        return STORE_ADDR_BITS'(slot) * STORE_ADDR_BITS'(MAX_HEIGHT)
             + STORE_ADDR_BITS'(row);
    endfunction

endpackage

FILE: hdl/apw_pixel_if.sv
// input pixel channel: valid/ready handshake with one pixel per transaction
// depends on apw_pkg
interface apw_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [apw_pkg::PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

FILE: hdl/apw_pool_if.sv
// result channel: valid/ready handshake with one pooled value per transaction
// depends on apw_pkg
interface apw_pool_if;
    logic                           valid;
    logic                           ready;
    logic [apw_pkg::PIXEL_BITS-1:0] pooled_value;
    logic                           frame_last;

    modport source (output valid, output pooled_value, output frame_last, input ready);
    modport sink   (input valid, input pooled_value, input frame_last, output ready);
endinterface

FILE: hdl/average_pooling_window.sv
// channel   | dir | payload                      | handshake
// i_pix     | in  | pixel_value[15:0]            | valid/ready
// o_pool    | out | pooled_value[15:0], frame_last | valid/ready
// i_cfg_*   | in  | index[1:0], data[12:0]       | write enable
//
// a pixel that completes no window is taken in the idle state; one that
// completes a window walks the read state, with one ram read per window
// pixel, then drain, the bit-serial divider and one output load before the
// next pixel is taken, so the ram read port and the divider hold the input.
// reset is synchronous and active low; it clears configuration, position and control only.
// the result register lets the next pixel enter while a result is stalled;
// a later result waits in the output state until that register frees up.
//
// top level of the average pooling window; depends on apw_pkg, apw_pixel_if,
// apw_pool_if, apw_ram, apw_divider and the assertion macro header
`include "average_pooling_window_defines.svh"

module average_pooling_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    apw_pixel_if.sink                           i_pix,
    apw_pool_if.source                          o_pool,
    input  logic                                i_cfg_we,
    input  logic [apw_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [apw_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // effective configuration
    logic [apw_pkg::POOL_BITS-1:0]   r_k;
    logic [apw_pkg::STRIDE_BITS-1:0] r_s;
    logic [apw_pkg::COL_BITS-1:0]    r_w_m1;
    logic [apw_pkg::ROW_BITS-1:0]    r_h_m1;

    // image position
    logic [apw_pkg::ROW_BITS-1:0]    r_row, n_row;
    logic [apw_pkg::COL_BITS-1:0]    r_col, n_col;
    logic [apw_pkg::SLOT_BITS-1:0]   r_slot, n_slot;
    logic [apw_pkg::STRIDE_BITS-1:0] r_row_ph, n_row_ph;
    logic [apw_pkg::STRIDE_BITS-1:0] r_col_ph, n_col_ph;

    // window read sequencer
    logic [apw_pkg::SLOT_BITS-1:0]   r_rd_slot;
    logic [apw_pkg::ROW_BITS-1:0]    r_rd_row;
    logic [apw_pkg::ROW_BITS-1:0]    r_rd_row0;
    logic [apw_pkg::ROW_BITS-1:0]    r_rd_row_end;
    logic                            r_rd_vld;
    logic [apw_pkg::SUM_BITS-1:0]    r_acc;
    logic                            r_last;

    logic                            r_out_valid;
    logic [apw_pkg::PIXEL_BITS-1:0]  r_out_value;
    logic                            r_out_last;

    logic                            accept;
    logic                            out_free;
    logic [apw_pkg::POOL_BITS-1:0]   k_m1;
    logic [apw_pkg::STRIDE_BITS-1:0] s_m1;
    logic                            row_end, col_end;
    logic                            win_hit, win_last;
    logic                            rd_wrap_row, rd_done;
    logic [apw_pkg::PIXEL_BITS-1:0]  rd_data;
    logic [apw_pkg::DIV_BITS-1:0]    divisor;
    logic                            round_up;
    logic [apw_pkg::PIXEL_BITS-1:0]  avg;

    logic [apw_pkg::POOL_BITS-1:0]   cfg_k;
    logic [apw_pkg::STRIDE_BITS-1:0] cfg_s;
    logic [apw_pkg::COL_BITS-1:0]    cfg_w_m1;
    logic [apw_pkg::ROW_BITS-1:0]    cfg_h_m1;
    logic [apw_pkg::WREG_BITS-1:0]   cfg_w;
    logic [apw_pkg::HREG_BITS-1:0]   cfg_h;

    apw_pkg::t_div_req div_req;
    apw_pkg::t_div_rsp div_rsp;

    assign accept      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = r_state == S_IDLE;
    assign out_free    = !r_out_valid || o_pool.ready;

    // ---------------- configuration ----------------
    always_comb begin
        cfg_k = i_cfg_data[apw_pkg::POOL_BITS-1:0];
        if (cfg_k == '0) begin
            cfg_k = apw_pkg::POOL_BITS'(1);
        end else if (cfg_k > apw_pkg::POOL_BITS'(apw_pkg::MAX_POOL)) begin
            cfg_k = apw_pkg::POOL_BITS'(apw_pkg::MAX_POOL);
        end

        cfg_s = i_cfg_data[apw_pkg::STRIDE_BITS-1:0];
        if (cfg_s == '0) begin
            cfg_s = apw_pkg::STRIDE_BITS'(1);
        end

        cfg_w = i_cfg_data[apw_pkg::WREG_BITS-1:0];
        if (cfg_w == '0) begin
            cfg_w = apw_pkg::WREG_BITS'(1);
        end else if (cfg_w > apw_pkg::WREG_BITS'(apw_pkg::MAX_WIDTH)) begin
            cfg_w = apw_pkg::WREG_BITS'(apw_pkg::MAX_WIDTH);
        end
        cfg_w_m1 = apw_pkg::COL_BITS'(cfg_w - 1'b1);

        cfg_h = i_cfg_data[apw_pkg::HREG_BITS-1:0];
        if (cfg_h == '0) begin
            cfg_h = apw_pkg::HREG_BITS'(1);
        end else if (cfg_h > apw_pkg::HREG_BITS'(apw_pkg::MAX_HEIGHT)) begin
            cfg_h = apw_pkg::HREG_BITS'(apw_pkg::MAX_HEIGHT);
        end
        cfg_h_m1 = apw_pkg::ROW_BITS'(cfg_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= apw_pkg::POOL_BITS'(2);
            r_s    <= apw_pkg::STRIDE_BITS'(2);
            r_w_m1 <= '0;
            r_h_m1 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                apw_pkg::CFG_POOL_SIZE: r_k    <= cfg_k;
                apw_pkg::CFG_STRIDE:    r_s    <= cfg_s;
                apw_pkg::CFG_IN_WIDTH:  r_w_m1 <= cfg_w_m1;
                apw_pkg::CFG_IN_HEIGHT: r_h_m1 <= cfg_h_m1;
                default: ;
            endcase
        end
    end

    // ---------------- position tracking ----------------
    always_comb begin
        k_m1    = r_k - 1'b1;
        s_m1    = r_s - 1'b1;
        row_end = r_row == r_h_m1;
        col_end = r_col == r_w_m1;

        // phases hold (pos - (k-1)) mod s once a full window fits
        win_hit = (r_row >= apw_pkg::ROW_BITS'(k_m1))
               && (r_col >= apw_pkg::COL_BITS'(k_m1))
               && (r_row_ph == '0) && (r_col_ph == '0);
        // last grid origin: the next origin would leave the image
        win_last = (({1'b0, r_row} + (apw_pkg::ROW_BITS + 1)'(r_s)) > {1'b0, r_h_m1})
                && (({1'b0, r_col} + (apw_pkg::COL_BITS + 1)'(r_s)) > {1'b0, r_w_m1});

        n_row    = r_row;
        n_col    = r_col;
        n_slot   = r_slot;
        n_row_ph = r_row_ph;
        n_col_ph = r_col_ph;
        if (row_end) begin
            n_row    = '0;
            n_row_ph = '0;
            if (col_end) begin
                n_col    = '0;
                n_slot   = '0;
                n_col_ph = '0;
            end else begin
                n_col  = r_col + 1'b1;
                n_slot = (r_slot == apw_pkg::SLOT_BITS'(k_m1)) ? '0 : r_slot + 1'b1;
                if (r_col < apw_pkg::COL_BITS'(k_m1)) begin
                    n_col_ph = '0;
                end else begin
                    n_col_ph = (r_col_ph == s_m1) ? '0 : r_col_ph + 1'b1;
                end
            end
        end else begin
            n_row = r_row + 1'b1;
            if (r_row < apw_pkg::ROW_BITS'(k_m1)) begin
                n_row_ph = '0;
            end else begin
                n_row_ph = (r_row_ph == s_m1) ? '0 : r_row_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_row_ph <= '0;
            r_col_ph <= '0;
        end else if (i_cfg_we) begin
            r_row    <= '0;
            r_col    <= '0;
            r_slot   <= '0;
            r_row_ph <= '0;
            r_col_ph <= '0;
        end else if (accept) begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_slot   <= n_slot;
            r_row_ph <= n_row_ph;
            r_col_ph <= n_col_ph;
        end
    end

    // ---------------- column store ----------------
    apw_ram #(
        .WIDTH (apw_pkg::PIXEL_BITS),
        .DEPTH (apw_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (apw_pkg::store_addr(r_slot, r_row)),
        .i_wr_data (i_pix.pixel_value),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (apw_pkg::store_addr(r_rd_slot, r_rd_row)),
        .o_rd_data (rd_data)
    );

    // ---------------- control ----------------
    always_comb begin
        rd_wrap_row = r_rd_row == r_rd_row_end;
        rd_done     = rd_wrap_row && (r_rd_slot == apw_pkg::SLOT_BITS'(k_m1));

        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (accept && win_hit) n_state = S_READ;
            S_READ:  if (rd_done) n_state = S_DRAIN;
            S_DRAIN: n_state = S_DIV;
            S_DIV:   if (div_rsp.done) n_state = S_OUT;
            S_OUT:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= r_state == S_READ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_slot    <= '0;
            r_rd_row     <= r_row - apw_pkg::ROW_BITS'(k_m1);
            r_rd_row0    <= r_row - apw_pkg::ROW_BITS'(k_m1);
            r_rd_row_end <= r_row;
            r_last       <= win_last;
        end else if (r_state == S_READ) begin
            if (rd_wrap_row) begin
                r_rd_row  <= r_rd_row0;
                r_rd_slot <= r_rd_slot + 1'b1;
            end else begin
                r_rd_row <= r_rd_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_acc + apw_pkg::SUM_BITS'(rd_data);
        end
    end

    // ---------------- divide and round ----------------
    assign divisor          = apw_pkg::pool_divisor(r_k);
    assign div_req.start    = r_state == S_DRAIN;
    assign div_req.dividend = r_acc + apw_pkg::SUM_BITS'(rd_data);
    assign div_req.divisor  = divisor;

    apw_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // half up: twice the remainder against the divisor
    assign round_up = {div_rsp.remainder, 1'b0} >= {1'b0, divisor};
    assign avg      = div_rsp.quotient[apw_pkg::PIXEL_BITS-1:0]
                    + apw_pkg::PIXEL_BITS'(round_up);

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_pool.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_value <= avg;
            r_out_last  <= r_last;
        end
    end

    assign o_pool.valid        = r_out_valid;
    assign o_pool.pooled_value = r_out_value;
    assign o_pool.frame_last   = r_out_last;

    // ---------------- assertions ----------------
    `APW_ASSERT_IMP(a_pos_in_image, i_clk, i_rst_n, 1'b1, r_row <= r_h_m1 && r_col <= r_w_m1)
    `APW_ASSERT_IMP(a_rd_slot_range, i_clk, i_rst_n, r_state == S_READ, r_rd_slot <= apw_pkg::SLOT_BITS'(k_m1))
    `APW_ASSERT_NXT(a_hit_starts_read, i_clk, i_rst_n, accept && win_hit, r_state == S_READ)
    `APW_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV)

endmodule

FILE: hdl/apw_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module apw_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 1280,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [WIDTH-1:0]     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/apw_divider.sv
// restoring divider, one quotient bit per cycle, for window sum by pool area
// depends on apw_pkg
module apw_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apw_pkg::t_div_req i_req,
    output apw_pkg::t_div_rsp o_rsp
);

    logic                             r_busy;
    logic                             r_done;
    logic [apw_pkg::CNT_BITS-1:0]     r_cnt;
    logic [apw_pkg::SUM_BITS-1:0]     r_quo;
    logic [apw_pkg::DIV_BITS-1:0]     r_rem;
    logic [apw_pkg::DIV_BITS-1:0]     r_div;

    logic [apw_pkg::DIV_BITS:0]       trial;
    logic                             trial_ge;
    logic [apw_pkg::DIV_BITS:0]       trial_sub;
    logic [apw_pkg::DIV_BITS-1:0]     n_rem;
    logic                             last_step;

    always_comb begin
        trial     = {r_rem, r_quo[apw_pkg::SUM_BITS-1]};
        trial_ge  = trial >= {1'b0, r_div};
        trial_sub = trial - {1'b0, r_div};
        n_rem     = trial_ge ? trial_sub[apw_pkg::DIV_BITS-1:0]
                             : trial[apw_pkg::DIV_BITS-1:0];
        last_step = r_cnt == apw_pkg::CNT_BITS'(apw_pkg::SUM_BITS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last_step) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[apw_pkg::SUM_BITS-2:0], trial_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: verif/apw_window_checker.sv
// checker of the average pooling window: watches the pixel, result and register ports,
// predicts every pooled value and its frame_last flag, and counts mismatches
// depends on apw_pkg, apw_pixel_if and apw_pool_if
module apw_window_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    apw_pixel_if                                i_pix,
    apw_pool_if                                 i_pool,
    input  logic                                i_cfg_we,
    input  logic [apw_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [apw_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_waiting,
    output int                                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import apw_pkg::*;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic                  last;
    } pooled_t;

    pooled_t                 avg_queue[$];
    logic [PIXEL_BITS-1:0]   pixel_store [STORE_DEPTH];

    logic [POOL_BITS-1:0]    pool_reg;
    logic [STRIDE_BITS-1:0]  stride_reg;
    logic [WREG_BITS-1:0]    width_reg;
    logic [HREG_BITS-1:0]    height_reg;
    int unsigned             row_pos;
    int unsigned             col_pos;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_fail_count++;
    endtask

    // stores one pixel and queues the average of the window it completes, if any
    function automatic void pool_pixel(input logic [PIXEL_BITS-1:0] pix);
        int unsigned k, s, w, h, r, c, r0, c0, total, area, rem, cc, rr;
        pooled_t res;
        k = (pool_reg == 0) ? 1 : ((pool_reg > MAX_POOL) ? MAX_POOL : pool_reg);
        s = (stride_reg == 0) ? 1 : stride_reg;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
        r = (row_pos >= h) ? 0 : row_pos;
        c = (col_pos >= w) ? 0 : col_pos;
        pixel_store[(c % k) * MAX_HEIGHT + r] = pix;

        if (r + 1 >= k && c + 1 >= k && k <= w && k <= h) begin
            r0 = r + 1 - k;
            c0 = c + 1 - k;
            if (r0 % s == 0 && c0 % s == 0) begin
                total = 0;
                for (cc = c0; cc <= c; cc++) begin
                    for (rr = r0; rr <= r; rr++) begin
                        total += pixel_store[(cc % k) * MAX_HEIGHT + rr];
                    end
                end
                area = k * k;
                rem = total % area;
                // round half up: doubled remainder against the divisor
                res.value = PIXEL_BITS'(total / area + ((rem * 2 >= area) ? 1 : 0));
                res.last  = (r0 == ((h - k) / s) * s) && (c0 == ((w - k) / s) * s);
                avg_queue.push_back(res);
            end
        end

        r++;
        if (r >= h) begin
            r = 0;
            c++;
            if (c >= w) begin
                c = 0;
            end
        end
        row_pos = r;
        col_pos = c;
    endfunction

    always @(posedge i_clk) begin
        pooled_t want;
        if (!i_rst_n) begin
            pool_reg   = 3'd2;
            stride_reg = 4'd2;
            width_reg  = 13'd1;
            height_reg = 9'd1;
            row_pos    = 0;
            col_pos    = 0;
            avg_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POOL_SIZE: pool_reg   = i_cfg_data[POOL_BITS-1:0];
                    CFG_STRIDE:    stride_reg = i_cfg_data[STRIDE_BITS-1:0];
                    CFG_IN_WIDTH:  width_reg  = i_cfg_data[WREG_BITS-1:0];
                    CFG_IN_HEIGHT: height_reg = i_cfg_data[HREG_BITS-1:0];
                    default: ;
                endcase
                // any register write starts a new image
                row_pos = 0;
                col_pos = 0;
            end
            if (i_pix.valid && i_pix.ready) begin
                pool_pixel(i_pix.pixel_value);
            end
            if (i_pool.valid && i_pool.ready) begin
                if (avg_queue.size() == 0) begin
                    report_mismatch($sformatf("pooled value %0h with nothing outstanding",
                                              i_pool.pooled_value));
                end else begin
                    want = avg_queue.pop_front();
                    o_checked++;
                    if (i_pool.pooled_value !== want.value) begin
                        report_mismatch($sformatf("pooled_value %0h, predicted %0h",
                                                  i_pool.pooled_value, want.value));
                    end
                    if (i_pool.frame_last !== want.last) begin
                        report_mismatch($sformatf("frame_last %b, predicted %b",
                                                  i_pool.frame_last, want.last));
                    end
                end
            end
        end
        o_waiting = avg_queue.size();
    end

endmodule

FILE: verif/tb_average_pooling_window.sv
// top of the average pooling window testbench: clock, reset, register writes,
// pixel stimulus with random gaps and result back-pressure, and the verdict
// depends on apw_pkg, apw_pixel_if, apw_pool_if, apw_window_checker and the rtl
module tb_average_pooling_window;
    timeunit 1ns;
    timeprecision 1ps;
    import apw_pkg::*;

    localparam int ITEM_TARGET   = 1200;
    localparam int SETTLE_CYCLES = 64;   // outlasts the processing of the longest, 5*5 window
    localparam int LONG_HOLD     = 400;
    localparam int MAX_GAP       = 11;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    int          fail_count;
    int          waiting;
    int          checked;
    int unsigned pixels_sent;
    int unsigned setting_count;
    int unsigned cur_pool, cur_stride, cur_width, cur_height;
    bit          quiet_tx;
    bit          quiet_rx;
    bit          long_hold_req;

    apw_pixel_if pix_ch ();
    apw_pool_if  pool_ch ();

    average_pooling_window u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_pool      (pool_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    apw_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_pool       (pool_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic int unsigned saturate(input int unsigned v, input int unsigned hi);
        return (v == 0) ? 1 : ((v > hi) ? hi : v);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return PIXEL_BITS'($urandom_range(65000, 65535));
            default: return PIXEL_BITS'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [PIXEL_BITS-1:0] value);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_value <= value;
        @(posedge i_clk);
        while (!(pix_ch.valid && pix_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(negedge i_clk);
    endtask

    // waits until every predicted result has come out, then lets the pipeline empty
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(input bit [3:0] mask, input int unsigned k, input int unsigned s,
                             input int unsigned w, input int unsigned h);
        drain();
        if (mask[0]) begin
            write_reg(CFG_POOL_SIZE, k);
            cur_pool = k;
        end
        if (mask[1]) begin
            write_reg(CFG_STRIDE, s);
            cur_stride = s;
        end
        if (mask[2]) begin
            write_reg(CFG_IN_WIDTH, w);
            cur_width = w;
        end
        if (mask[3]) begin
            write_reg(CFG_IN_HEIGHT, h);
            cur_height = h;
        end
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // result side: random hold-off per transaction, one long stall on request
    initial begin
        int gap;
        pool_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                gap = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                gap = quiet_rx ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap != 0) begin
                pool_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pool_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(pool_ch.valid && pool_ch.ready)) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    initial begin
        bit [3:0]    mask;
        int unsigned k, s, w, h, ke, n;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel_value = '0;
        quiet_tx           = 1'b0;
        quiet_rx           = 1'b0;
        long_hold_req      = 1'b0;
        pixels_sent        = 0;
        setting_count      = 0;
        cur_pool           = 2;
        cur_stride         = 2;
        cur_width          = 1;
        cur_height         = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: 2x2 window never fits a 1x1 image
        send_pixel('1);
        send_pixel('0);

        // full-scale window, then averages below and at one half
        configure(4'hF, 2, 1, 2, 2);
        repeat (4) send_pixel('1);
        send_pixel(0); send_pixel(0); send_pixel(0); send_pixel(1);
        send_pixel(0); send_pixel(1); send_pixel(0); send_pixel(1);

        // all-zero registers act as a 1x1 window on a 1x1 image
        configure(4'hF, 0, 0, 0, 0);
        send_pixel(16'hA5A5);
        send_pixel(16'h5A5A);

        // registers above range saturate
        configure(4'hF, 7, 15, 8191, 511);
        repeat (3) send_pixel(random_pixel());
        // write in the middle of an image restarts it
        configure(4'b0001, 6, 0, 0, 0);
        repeat (2) send_pixel(random_pixel());
        configure(4'hF, MAX_POOL, 8, MAX_WIDTH, MAX_HEIGHT);
        repeat (2) send_pixel(random_pixel());

        // every pixel gives a result while the result side stalls: input must back up
        configure(4'hF, 1, 1, 8, 8);
        long_hold_req = 1'b1;
        repeat (64) send_pixel(random_pixel());

        while (pixels_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: k = 0;
                1: k = $urandom_range(MAX_POOL + 1, 7);
                default: k = $urandom_range(1, MAX_POOL);
            endcase
            case ($urandom_range(0, 9))
                0: s = 0;
                1: s = $urandom_range(9, 15);
                default: s = $urandom_range(1, 8);
            endcase
            ke = saturate(k, MAX_POOL);
            case ($urandom_range(0, 9))
                0: begin   // image often smaller than the window
                    w = $urandom_range(0, ke);
                    h = $urandom_range(0, ke);
                end
                1: begin   // tall, narrow image
                    w = ke;
                    h = $urandom_range(0, 1) ? $urandom_range(MAX_HEIGHT - 56, MAX_HEIGHT)
                                             : $urandom_range(MAX_HEIGHT + 1, 511);
                end
                2: begin
                    w = $urandom_range(ke, 40);
                    h = ke;
                end
                default: begin
                    w = $urandom_range(ke, 12);
                    h = $urandom_range(ke, 12);
                end
            endcase
            mask = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
            configure(mask, k, s, w, h);
            quiet_tx = ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            n = saturate(cur_width, MAX_WIDTH) * saturate(cur_height, MAX_HEIGHT)
              * $urandom_range(1, 3);
            if (n > 400) n = 400;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            repeat (n) send_pixel(random_pixel());
        end

        drain();
        $display("pooling run: %0d pixels under %0d register settings, %0d results checked",
                 pixels_sent, setting_count, checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("run timed out");
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
